FILE: hw/rtl/gul_pkg.sv
package gul_pkg;

   localparam int COORD_BITS = 7;
   localparam int CFG_BITS   = 7;
   localparam int CODES      = 8;
   localparam int CODE_BITS  = 3;
   localparam int BANKS      = 8;
   localparam int BANK_BITS  = 3;

   localparam logic REG_DIMENSION_MODE = 1'b0;
   localparam logic REG_COARSE_WIDTH   = 1'b1;

   localparam logic [CFG_BITS-1:0] WIDTH_RESET = 7'd64;
   localparam logic [CFG_BITS-1:0] WIDTH_MIN   = 7'd2;

   typedef logic [CODES-1:0] code_mask_type;

   localparam code_mask_type LAST_MASK = code_mask_type'(1);

   typedef struct packed {
      logic          load;
      code_mask_type mask;
      logic          x_odd;
      logic          y_odd;
      logic          plane;
   } load_type;

endpackage

FILE: hw/rtl/gul_req_if.sv
interface gul_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] coarse_value;

   modport source (output valid, output coarse_value, input ready);
   modport sink (input valid, input coarse_value, output ready);
endinterface

FILE: hw/rtl/gul_rsp_if.sv
interface gul_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                                valid;
   logic                                ready;
   logic signed [SAMPLE_BITS-1:0]       fine_value;
   logic [gul_pkg::COORD_BITS-1:0]      fine_x;
   logic [gul_pkg::COORD_BITS-1:0]      fine_y;
   logic [gul_pkg::COORD_BITS-1:0]      fine_z;
   logic                                last_of_run;

   modport source (
      output valid, output fine_value, output fine_x, output fine_y, output fine_z,
      output last_of_run, input ready
   );
   modport sink (
      input valid, input fine_value, input fine_x, input fine_y, input fine_z,
      input last_of_run, output ready
   );
endinterface

FILE: hw/rtl/gul_history.sv
module gul_history #(
   parameter int SAMPLE_BITS = 16,
   parameter int ADDR_BITS   = 10
) (
   input  logic                              clock,
   input  logic                              write_enable,
   input  logic [gul_pkg::BANK_BITS-1:0]     write_bank,
   input  logic [ADDR_BITS-1:0]              write_addr,
   input  logic signed [SAMPLE_BITS-1:0]     write_data,
   input  logic                              read_enable,
   input  logic [ADDR_BITS-1:0]              read_addr [4],
   output logic signed [SAMPLE_BITS-1:0]     read_data [gul_pkg::BANKS]
);

   localparam int DEPTH = 2 ** ADDR_BITS;

   // bank code is {plane, y parity, x parity}
   for (genvar gb = 0; gb < gul_pkg::BANKS; gb++) begin : g_bank
      logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
      logic signed [SAMPLE_BITS-1:0] rd_ff;

      always_ff @(posedge clock) begin
         if (write_enable && write_bank == gul_pkg::BANK_BITS'(gb)) begin
            mem[write_addr] <= write_data;
         end
         if (read_enable) begin
            rd_ff <= mem[read_addr[gb % 4]];
         end
      end

      assign read_data[gb] = rd_ff;
   end

endmodule

FILE: hw/rtl/gul_emit.sv
module gul_emit #(
   parameter int SAMPLE_BITS = 16,
   parameter int POS_BITS    = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gul_pkg::load_type             load,
   input  logic [POS_BITS-1:0]           load_x,
   input  logic [POS_BITS-1:0]           load_y,
   input  logic [POS_BITS-1:0]           load_z,
   input  logic signed [SAMPLE_BITS-1:0] load_sample,
   input  logic signed [SAMPLE_BITS-1:0] corner_data [gul_pkg::BANKS],
   output logic                          work_ready,
   gul_rsp_if.source                     rsp
);

   localparam int SUM_BITS = SAMPLE_BITS + 3;

   gul_pkg::code_mask_type          mask_ff, mask_in;
   logic [POS_BITS-1:0]             x_ff, y_ff, z_ff;
   logic                            x_odd_ff, y_odd_ff, plane_ff;
   logic signed [SAMPLE_BITS-1:0]   sample_ff;

   logic                            out_valid_ff, out_valid_in;
   logic signed [SAMPLE_BITS-1:0]   value_ff, value_in;
   logic [gul_pkg::COORD_BITS-1:0]  fx_ff, fx_in, fy_ff, fy_in, fz_ff, fz_in;
   logic                            last_ff, last_in;

   logic [gul_pkg::CODE_BITS-1:0]   code_sel;
   logic signed [SAMPLE_BITS-1:0]   corner_val [gul_pkg::CODES];
   logic signed [SUM_BITS-1:0]      sum;
   logic [1:0]                      shift_k;
   logic                            out_free;
   logic                            step;

   // highest pending offset code goes first
   always_comb begin
      code_sel = '0;
      for (int i = 0; i < gul_pkg::CODES; i++) begin
         if (mask_ff[i]) begin
            code_sel = gul_pkg::CODE_BITS'(i);
         end
      end
   end

   // corner {c,b,a}: plane toggles with c, parities with b and a
   always_comb begin
      for (int i = 0; i < gul_pkg::CODES; i++) begin
         logic [gul_pkg::CODE_BITS-1:0] ci;
         ci = gul_pkg::CODE_BITS'(i);
         corner_val[i] = corner_data[{plane_ff ^ ci[2], y_odd_ff ^ ci[1], x_odd_ff ^ ci[0]}];
      end
      corner_val[0] = sample_ff;
   end

   always_comb begin
      sum = '0;
      for (int i = 0; i < gul_pkg::CODES; i++) begin
         if ((gul_pkg::CODE_BITS'(i) & ~code_sel) == '0) begin
            sum = sum + SUM_BITS'(corner_val[i]);
         end
      end
      shift_k = 2'(code_sel[0]) + 2'(code_sel[1]) + 2'(code_sel[2]);
   end

   assign out_free   = !out_valid_ff || rsp.ready;
   assign step       = (mask_ff != '0) && out_free;
   assign work_ready = (mask_ff == '0) || (step && mask_ff == gul_pkg::LAST_MASK);

   always_comb begin
      mask_in = mask_ff;
      if (load.load) begin
         mask_in = load.mask;
      end else if (step) begin
         mask_in = mask_ff & ~(gul_pkg::code_mask_type'(1) << code_sel);
      end

      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end

      value_in = SAMPLE_BITS'(sum >>> shift_k);
      fx_in    = gul_pkg::COORD_BITS'({x_ff, 1'b0} - (POS_BITS + 1)'(code_sel[0]));
      fy_in    = gul_pkg::COORD_BITS'({y_ff, 1'b0} - (POS_BITS + 1)'(code_sel[1]));
      fz_in    = gul_pkg::COORD_BITS'({z_ff, 1'b0} - (POS_BITS + 1)'(code_sel[2]));
      last_in  = (code_sel == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load.load) begin
         x_ff      <= load_x;
         y_ff      <= load_y;
         z_ff      <= load_z;
         x_odd_ff  <= load.x_odd;
         y_odd_ff  <= load.y_odd;
         plane_ff  <= load.plane;
         sample_ff <= load_sample;
      end
      if (step) begin
         value_ff <= value_in;
         fx_ff    <= fx_in;
         fy_ff    <= fy_in;
         fz_ff    <= fz_in;
         last_ff  <= last_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.fine_value  = value_ff;
   assign rsp.fine_x      = fx_ff;
   assign rsp.fine_y      = fy_ff;
   assign rsp.fine_z      = fz_ff;
   assign rsp.last_of_run = last_ff;

endmodule

FILE: hw/rtl/grid_upsample_linear_interp.sv
// Refines a coarse 2D or 3D grid by two with linear interpolation.
// req_chan carries coarse samples in raster order, x fastest, then y, then z.
// rsp_chan carries fine nodes (value, x, y, z); each coarse sample yields the
// 1 to 8 fine nodes it completes, highest offset first, and the even node
// (2X,2Y,2Z) closes the run with last_of_run set.
// csr: index 0 selects 2D/3D, index 1 sets the coarse width; any write
// restarts the grid at the origin. Write only while the block is idle.
// A sample's beat loads the emitter and reads its stored corners into the bank
// registers; its results then move one by one to the output register.
// Throughput: one result per cycle while rsp_chan is not stalled; a sample
// has 1 to 4 results in 2D and 1 to 8 in 3D, and the next sample is taken in
// the cycle its predecessor's last result moves to the output register.
// Past samples live in eight banks (plane x y parity x x parity), so all
// seven stored corners are read in the beat cycle.
// Reset clears position, plane select, registers and the output; the sample
// store is not cleared, entries are read only after the current grid wrote them.
// When rsp_chan stalls, the output register holds and emission pauses.
module grid_upsample_linear_interp #(
   parameter int MAX_WIDTH   = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   gul_req_if.sink                       req_chan,
   gul_rsp_if.source                     rsp_chan,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [gul_pkg::CFG_BITS-1:0]  csr_write_data
);

   localparam int WIDTH_CAP = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
   localparam int EW        = $clog2(WIDTH_CAP + 1);
   localparam int PW        = $clog2(WIDTH_CAP);
   localparam int HW        = (PW > 1) ? PW - 1 : 1;
   localparam int AW        = 2 * HW;

   logic                          dim_ff, dim_in;
   logic [gul_pkg::CFG_BITS-1:0]  cw_ff, cw_in;
   logic [PW-1:0]                 pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, pos_z_ff, pos_z_in;
   logic                          plane_ff, plane_in;

   logic [EW-1:0]                 eff_w;
   logic [PW-1:0]                 cx, cy, cz;
   logic                          accept;
   logic                          work_ready;
   gul_pkg::load_type             load;
   gul_pkg::code_mask_type        mask;

   logic [AW-1:0]                 write_addr;
   logic [AW-1:0]                 read_addr [4];
   logic signed [SAMPLE_BITS-1:0] corner_data [gul_pkg::BANKS];

   always_comb begin
      if (cw_ff < gul_pkg::WIDTH_MIN) begin
         eff_w = EW'(gul_pkg::WIDTH_MIN);
      end else if (cw_ff > gul_pkg::CFG_BITS'(WIDTH_CAP)) begin
         eff_w = EW'(WIDTH_CAP);
      end else begin
         eff_w = EW'(cw_ff);
      end
   end

   always_comb begin
      cx = (EW'(pos_x_ff) >= eff_w) ? '0 : pos_x_ff;
      cy = (EW'(pos_y_ff) >= eff_w) ? '0 : pos_y_ff;
      cz = (!dim_ff || EW'(pos_z_ff) >= eff_w) ? '0 : pos_z_ff;
   end

   assign req_chan.ready = work_ready;
   assign accept         = req_chan.valid && work_ready;

   // offsets that would step below the origin are dropped; 2D has cz at zero
   always_comb begin
      for (int c = 0; c < gul_pkg::CODES; c++) begin
         logic [gul_pkg::CODE_BITS-1:0] cc;
         cc = gul_pkg::CODE_BITS'(c);
         mask[c] = !(cc[0] && cx == '0) && !(cc[1] && cy == '0) && !(cc[2] && cz == '0);
      end
   end

   always_comb begin
      load.load  = accept;
      load.mask  = mask;
      load.x_odd = cx[0];
      load.y_odd = cy[0];
      load.plane = plane_ff;
   end

   // bank address is {y/2, x/2}; banks of the other parity read at x-1 or y-1
   always_comb begin
      write_addr = {HW'(cy >> 1), HW'(cx >> 1)};
      for (int r = 0; r < 4; r++) begin
         logic [1:0]    rr;
         logic [PW-1:0] xr, yr;
         rr = 2'(r);
         xr = (cx[0] == rr[0]) ? cx : cx - PW'(1);
         yr = (cy[0] == rr[1]) ? cy : cy - PW'(1);
         read_addr[r] = {HW'(yr >> 1), HW'(xr >> 1)};
      end
   end

   always_comb begin
      dim_in   = dim_ff;
      cw_in    = cw_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      plane_in = plane_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            gul_pkg::REG_DIMENSION_MODE: dim_in = csr_write_data[0];
            gul_pkg::REG_COARSE_WIDTH:   cw_in  = csr_write_data;
         endcase
         pos_x_in = '0;
         pos_y_in = '0;
         pos_z_in = '0;
         plane_in = 1'b0;
      end else if (accept) begin
         pos_x_in = cx + PW'(1);
         pos_y_in = cy;
         pos_z_in = cz;
         if (EW'(cx) + EW'(1) >= eff_w) begin
            pos_x_in = '0;
            pos_y_in = cy + PW'(1);
            if (EW'(cy) + EW'(1) >= eff_w) begin
               pos_y_in = '0;
               if (dim_ff) begin
                  plane_in = !plane_ff;
                  pos_z_in = (EW'(cz) + EW'(1) >= eff_w) ? '0 : cz + PW'(1);
               end
            end
         end
         if (!dim_ff) begin
            pos_z_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff   <= 1'b0;
         cw_ff    <= gul_pkg::WIDTH_RESET;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
         plane_ff <= 1'b0;
      end else begin
         dim_ff   <= dim_in;
         cw_ff    <= cw_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
         plane_ff <= plane_in;
      end
   end

   gul_history #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .ADDR_BITS   (AW)
   ) u_history (
      .clock        (clock),
      .write_enable (accept),
      .write_bank   ({plane_ff, cy[0], cx[0]}),
      .write_addr   (write_addr),
      .write_data   (req_chan.coarse_value),
      .read_enable  (accept),
      .read_addr    (read_addr),
      .read_data    (corner_data)
   );

   gul_emit #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .POS_BITS    (PW)
   ) u_emit (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .load_x      (cx),
      .load_y      (cy),
      .load_z      (cz),
      .load_sample (req_chan.coarse_value),
      .corner_data (corner_data),
      .work_ready  (work_ready),
      .rsp         (rsp_chan)
   );

endmodule

FILE: tb/sv/gul_refine_checker.sv
module gul_refine_checker #(
   parameter int MAX_WIDTH   = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   gul_req_if                           req_chan,
   gul_rsp_if                           rsp_chan,
   input  logic                         csr_write_enable,
   input  logic                         csr_index,
   input  logic [gul_pkg::CFG_BITS-1:0] csr_write_data,
   output int unsigned                  backlog,
   output int unsigned                  mismatches
);

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0]      value;
      logic [gul_pkg::COORD_BITS-1:0]     fx;
      logic [gul_pkg::COORD_BITS-1:0]     fy;
      logic [gul_pkg::COORD_BITS-1:0]     fz;
      logic                               last;
   } fine_node_type;

   logic signed [SAMPLE_BITS-1:0] history [2][MAX_WIDTH][MAX_WIDTH];
   logic                          dim_3d;
   logic [gul_pkg::CFG_BITS-1:0]  width_cfg;
   int                            at_x;
   int                            at_y;
   int                            at_z;
   logic                          plane;
   fine_node_type                 due_nodes [$];

   task automatic restart_grid();
      at_x  = 0;
      at_y  = 0;
      at_z  = 0;
      plane = 1'b0;
   endtask

   task automatic refine_sample(input logic signed [SAMPLE_BITS-1:0] sample);
      int            w;
      int            x;
      int            y;
      int            z;
      int            dx;
      int            dy;
      int            dz;
      int            sum;
      logic          cur;
      logic          pl;
      fine_node_type node;
      w   = (width_cfg < gul_pkg::WIDTH_MIN) ? gul_pkg::WIDTH_MIN :
            (width_cfg > MAX_WIDTH) ? MAX_WIDTH : width_cfg;
      x   = at_x;
      y   = at_y;
      z   = dim_3d ? at_z : 0;
      cur = plane;
      history[cur][y][x] = sample;
      for (int code = gul_pkg::CODES - 1; code >= 0; code--) begin
         dx = code & 1;
         dy = (code >> 1) & 1;
         dz = (code >> 2) & 1;
         if (dz != 0 && !dim_3d) continue;
         if ((dx != 0 && x == 0) || (dy != 0 && y == 0) || (dz != 0 && z == 0)) continue;
         sum = 0;
         for (int c = 0; c <= dz; c++) begin
            pl = (c != 0) ? ~cur : cur;
            for (int b = 0; b <= dy; b++) begin
               for (int a = 0; a <= dx; a++) begin
                  sum += history[pl][y - b][x - a];
               end
            end
         end
         node.value = SAMPLE_BITS'(sum >>> (dx + dy + dz));
         node.fx    = gul_pkg::COORD_BITS'(2 * x - dx);
         node.fy    = gul_pkg::COORD_BITS'(2 * y - dy);
         node.fz    = gul_pkg::COORD_BITS'(2 * z - dz);
         node.last  = (code == 0);
         due_nodes.push_back(node);
      end
      x++;
      if (x >= w) begin
         x = 0;
         y++;
         if (y >= w) begin
            y = 0;
            if (dim_3d) begin
               z++;
               plane = ~cur;
               if (z >= w) z = 0;
            end
         end
      end
      at_x = x;
      at_y = y;
      at_z = dim_3d ? z : 0;
   endtask

   always @(posedge clock) begin : watch
      fine_node_type got;
      fine_node_type want;
      if (reset) begin
         dim_3d     = 1'b0;
         width_cfg  = gul_pkg::WIDTH_RESET;
         mismatches = 0;
         restart_grid();
         due_nodes.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == gul_pkg::REG_DIMENSION_MODE) dim_3d = csr_write_data[0];
            else width_cfg = csr_write_data;
            restart_grid();
         end
         if (req_chan.valid && req_chan.ready) refine_sample(req_chan.coarse_value);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.value = rsp_chan.fine_value;
            got.fx    = rsp_chan.fine_x;
            got.fy    = rsp_chan.fine_y;
            got.fz    = rsp_chan.fine_z;
            got.last  = rsp_chan.last_of_run;
            if (due_nodes.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected fine beat: value %0d at (%0d,%0d,%0d) last %0b",
                           got.value, got.fx, got.fy, got.fz, got.last);
            end else begin
               want = due_nodes.pop_front();
               if (got.value !== want.value || got.fx !== want.fx || got.fy !== want.fy ||
                   got.fz !== want.fz || got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display({"fine node: expected %0d at (%0d,%0d,%0d) last %0b, ",
                               "got %0d at (%0d,%0d,%0d) last %0b"},
                              want.value, want.fx, want.fy, want.fz, want.last,
                              got.value, got.fx, got.fy, got.fz, got.last);
               end
            end
         end
      end
      backlog <= due_nodes.size();
   end

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;

   localparam int MAX_WIDTH     = 64;
   localparam int SAMPLE_BITS   = 16;
   localparam int TOTAL_ITEMS   = 310;
   localparam int CALM_TAIL     = 60;
   localparam int QUIET_LIMIT   = 2000;
   localparam int LONG_HOLD     = 200;
   localparam int SETTLE_CYCLES = 4;
   localparam int SQUEEZE_PHASE = 1;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic                         clock;
   logic                         reset;
   logic                         csr_write_enable;
   logic                         csr_index;
   logic [gul_pkg::CFG_BITS-1:0] csr_write_data;
   logic                         calm;
   logic                         jitter;
   logic                         squeeze_go;
   int unsigned                  backlog;
   int unsigned                  mismatches;

   gul_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_chan ();
   gul_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_chan ();

   grid_upsample_linear_interp #(
      .MAX_WIDTH   (MAX_WIDTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   gul_refine_checker #(
      .MAX_WIDTH   (MAX_WIDTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .backlog          (backlog),
      .mismatches       (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return SAMPLE_MIN;
         1: return SAMPLE_MAX;
         2: return SAMPLE_BITS'($urandom_range(0, 8)) - SAMPLE_BITS'(4);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] sample);
      if (jitter && !calm && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.coarse_value <= sample;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic drain_block();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (backlog != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic three, input logic [gul_pkg::CFG_BITS-1:0] w);
      logic width_first;
      width_first = 1'($urandom);
      drain_block();
      for (int i = 0; i < 2; i++) begin
         csr_write_enable <= 1'b1;
         if ((i == 0) == width_first) begin
            csr_index      <= gul_pkg::REG_COARSE_WIDTH;
            csr_write_data <= w;
         end else begin
            csr_index      <= gul_pkg::REG_DIMENSION_MODE;
            csr_write_data <= {(gul_pkg::CFG_BITS-1)'($urandom), three};
         end
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   initial begin : rsp_drive
      int   stall_left;
      int   hold_left;
      logic squeezed;
      stall_left = 0;
      hold_left  = 0;
      squeezed   = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze_go && !squeezed) begin
            squeezed  = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0 && !calm) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (jitter && !calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 9);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) quiet = 0;
         else quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic signed [SAMPLE_BITS-1:0] square [5];
      logic signed [SAMPLE_BITS-1:0] cube [9];
      logic signed [SAMPLE_BITS-1:0] stripes [4];
      logic                          three;
      logic [gul_pkg::CFG_BITS-1:0]  w;
      int                            side;
      int                            grid;
      int                            count;
      int                            sent;
      int                            phase;

      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.coarse_value <= '0;
      csr_write_enable      <= 1'b0;
      csr_index             <= gul_pkg::REG_DIMENSION_MODE;
      csr_write_data        <= '0;
      calm                  <= 1'b0;
      jitter                <= 1'b0;
      squeeze_go            <= 1'b0;
      square  = '{SAMPLE_MAX, SAMPLE_MIN, -1, 0, 1};
      cube    = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, -1, SAMPLE_MAX,
                  SAMPLE_MIN, 5};
      stripes = '{16'sh5555, -16'sh5556, 1, -2};
      repeat (8) @(posedge clock);
      reset  <= 1'b0;
      jitter <= 1'b1;

      // smallest grids hit every offset, the extra beat wraps to the origin
      configure(1'b0, gul_pkg::WIDTH_MIN);
      foreach (square[i]) push_sample(square[i]);
      configure(1'b1, gul_pkg::WIDTH_MIN);
      foreach (cube[i]) push_sample(cube[i]);
      // out of range widths clamp
      configure(1'b0, gul_pkg::CFG_BITS'(1));
      foreach (stripes[i]) push_sample(stripes[i]);
      configure(1'b1, '1);
      repeat (3) push_sample(pick_sample());
      configure(1'b0, gul_pkg::CFG_BITS'(0));
      repeat (4) push_sample(pick_sample());
      sent = 25;

      // full width row reaches the far fine x edge
      configure(1'b0, gul_pkg::WIDTH_RESET);
      repeat (70) push_sample(pick_sample());
      sent += 70;

      phase = 0;
      while (sent < TOTAL_ITEMS) begin
         phase++;
         three = 1'($urandom);
         case ($urandom_range(0, 9))
            0: w = gul_pkg::CFG_BITS'($urandom);
            1: w = gul_pkg::WIDTH_RESET;
            default: w = gul_pkg::CFG_BITS'($urandom_range(2, three ? 4 : 6));
         endcase
         side  = (w < gul_pkg::WIDTH_MIN) ? gul_pkg::WIDTH_MIN : (w > MAX_WIDTH) ? MAX_WIDTH : w;
         grid  = three ? side * side * side : side * side;
         if (grid > 100) count = $urandom_range(10, 60);
         else if ($urandom_range(0, 4) == 0) count = $urandom_range(1, grid - 1);
         else count = grid * $urandom_range(1, 2);
         if (phase == SQUEEZE_PHASE) begin
            three = 1'b1;
            w     = gul_pkg::CFG_BITS'(3);
            count = 54;
         end
         if (count > TOTAL_ITEMS - sent) count = TOTAL_ITEMS - sent;
         calm   <= (sent + count >= TOTAL_ITEMS) || (sent >= TOTAL_ITEMS - CALM_TAIL);
         jitter <= ($urandom_range(0, 3) != 0);
         configure(three, w);
         if (phase == SQUEEZE_PHASE) squeeze_go <= 1'b1;
         repeat (count) push_sample(pick_sample());
         sent += count;
      end

      drain_block();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && backlog == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
